>>> hw/rtl/min_tracking_stack_defines.svh
// Assertion macros shared by the min tracking stack RTL.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Same-cycle check: when ante holds, cons must hold at the same edge.
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold at the following edge.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/mts_pkg.sv
// Shared types and constants of the min tracking stack.
// No dependencies; used by mts_ctrl, mts_dp and min_tracking_stack.
`timescale 1ns / 1ps
`default_nettype none

package mts_pkg;

    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_QUERY = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic exec;       // apply the accepted transaction
        logic load_top;   // reload top registers from memory read data
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_fetch; // pop leaves entries: new top must come from memory
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hw/rtl/mts_ctrl.sv
// Controller of the min tracking stack: input/output handshake sequencing.
// Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mts_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  mts_pkg::t_dp_stat i_stat,
    output mts_pkg::t_dp_cmd  o_cmd
);
    import mts_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FETCH = 3'b010,
        S_RESP  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_RESP);
    assign accept       = i_in_valid && o_in_ready;
    assign o_cmd.exec     = accept;
    assign o_cmd.load_top = (r_state == S_FETCH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_stat.need_fetch ? S_FETCH : S_RESP;
                end
            end
            S_FETCH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/mts_dp.sv
// Datapath of the min tracking stack: value and minimum memories, top and
// bottom registers, count and result registers. Depends on mts_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "min_tracking_stack_defines.svh"

module mts_dp (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  mts_pkg::t_dp_cmd                 i_cmd,
    output mts_pkg::t_dp_stat                o_stat,
    input  mts_pkg::t_opcode                 i_opcode,
    input  wire signed [mts_pkg::DATA_W-1:0] i_push_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_popped_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_min_value,
    output logic signed [mts_pkg::DATA_W-1:0] o_bottom_value,
    output logic [mts_pkg::CNT_W-1:0]        o_entry_count,
    output logic                             o_is_empty,
    output logic                             o_is_full,
    output mts_pkg::t_status                 o_status
);
    import mts_pkg::*;

    logic signed [DATA_W-1:0] mem_val [DEPTH];
    logic signed [DATA_W-1:0] mem_min [DEPTH];

    logic [CNT_W-1:0]         r_count, n_count;
    logic signed [DATA_W-1:0] r_top, n_top;
    logic signed [DATA_W-1:0] r_top_min, n_top_min;
    logic signed [DATA_W-1:0] r_bottom, n_bottom;
    logic signed [DATA_W-1:0] r_popped, n_popped;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_rd_val, r_rd_min;

    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] push_min;
    logic                     empty, full;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(DEPTH));
    assign wr_addr = r_count[ADDR_W-1:0];
    // entry just below the top: becomes the new top after a pop
    assign rd_addr = ADDR_W'(r_count - CNT_W'(2));
    assign push_min = (!empty && !(i_push_value <= r_top_min)) ? r_top_min : i_push_value;

    assign o_stat.need_fetch = (i_opcode == OP_POP) && (r_count > CNT_W'(1));

    always_comb begin
        n_count   = r_count;
        n_top     = r_top;
        n_top_min = r_top_min;
        n_bottom  = r_bottom;
        n_popped  = r_popped;
        n_status  = r_status;
        wr_en     = 1'b0;
        if (i_cmd.exec) begin
            n_popped = '0;
            n_status = ST_OK;
            case (i_opcode)
                OP_PUSH: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        wr_en     = 1'b1;
                        n_top     = i_push_value;
                        n_top_min = push_min;
                        if (empty) begin
                            n_bottom = i_push_value;
                        end
                        n_count = r_count + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_popped = r_top;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    n_count = '0;
                end
                OP_QUERY: begin
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load_top) begin
            n_top     = r_rd_val;
            n_top_min = r_rd_min;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_val[wr_addr] <= i_push_value;
            mem_min[wr_addr] <= push_min;
        end
        r_rd_val <= mem_val[rd_addr];
        r_rd_min <= mem_min[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_status <= ST_OK;
        end else begin
            r_count  <= n_count;
            r_status <= n_status;
        end
        r_top     <= n_top;
        r_top_min <= n_top_min;
        r_bottom  <= n_bottom;
        r_popped  <= n_popped;
    end

    assign o_popped_value = r_popped;
    assign o_top_value    = empty ? '0 : r_top;
    assign o_min_value    = empty ? '0 : r_top_min;
    assign o_bottom_value = empty ? '0 : r_bottom;
    assign o_entry_count  = r_count;
    assign o_is_empty     = empty;
    assign o_is_full      = full;
    assign o_status       = r_status;

    `MTS_ASSERT_NOW(a_count_range, 1'b1, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `MTS_ASSERT_NOW(a_cmd_exclusive, i_cmd.load_top, !i_cmd.exec, "reload during execute")
    `MTS_ASSERT_NEXT(a_push_grows, i_cmd.exec && i_opcode == OP_PUSH && !full, r_count == $past(r_count) + CNT_W'(1), "push did not grow stack")
    `MTS_ASSERT_NEXT(a_underflow_keeps, i_cmd.exec && i_opcode == OP_POP && empty, r_count == '0 && r_status == ST_UNDERFLOW, "pop on empty mishandled")

endmodule

`default_nettype wire

>>> hw/rtl/min_tracking_stack.sv
// Top level of the min tracking stack: stream ports, field packing.
// Depends on mts_pkg, mts_ctrl and mts_dp.
`timescale 1ns / 1ps
`default_nettype none

// Bounded LIFO of 64 signed 32-bit entries that also tracks the running
// minimum. Each input transaction carries an opcode (push, pop, clear,
// query) and answers with exactly one output transaction that reports the
// popped value, the top, the minimum, the oldest entry, the count, the
// empty/full flags and a status (ok, underflow, overflow). Pop on empty and
// push on full leave the stack untouched and only flag the status. One
// transaction is in flight at a time: push, clear, query and a pop that
// empties the stack or underflows present their result in the cycle after
// acceptance; a pop that leaves entries first passes through a fetch state,
// in which the registered read of the value/minimum memories reloads the
// new top. A new transaction is accepted only once the result has been
// taken. The memories need no clearing pass after reset.
module min_tracking_stack (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  wire  [31:0]   i_s_axis_tdata,   // [31:0] push_value
    input  wire  [1:0]    i_s_axis_tuser,   // [1:0] opcode
    output logic          o_m_axis_tvalid,
    input  wire           i_m_axis_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] min_value,
    // [127:96] bottom_value, [134:128] entry_count, [135] is_empty,
    // [136] is_full, [138:137] status, [143:139] zero
    output logic [143:0]  o_m_axis_tdata
);
    import mts_pkg::*;

    t_dp_cmd                  cmd;
    t_dp_stat                 stat;
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] bottom_value;
    logic [CNT_W-1:0]         entry_count;
    logic                     is_empty;
    logic                     is_full;
    t_status                  status;

    // handshake sequencing: accept, optional memory fetch, hold result
    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // storage and result registers; results stay stable while held
    mts_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_opcode       (t_opcode'(i_s_axis_tuser)),
        .i_push_value   (i_s_axis_tdata[DATA_W-1:0]),
        .o_popped_value (popped_value),
        .o_top_value    (top_value),
        .o_min_value    (min_value),
        .o_bottom_value (bottom_value),
        .o_entry_count  (entry_count),
        .o_is_empty     (is_empty),
        .o_is_full      (is_full),
        .o_status       (status)
    );

    // pack result fields, lowest field first, pad to whole bytes
    assign o_m_axis_tdata = {5'b0, status, is_full, is_empty, entry_count,
                             bottom_value, min_value, top_value, popped_value};

endmodule

`default_nettype wire
